@@ rtl/rds_pkg.sv @@
// Shared types and constants for the reaction-diffusion stencil step.
package rds_pkg;

    localparam int DATA_W = 32;
    localparam int ROW_W  = 10;
    localparam int COL_W  = 6;
    localparam int GAIN_W = 24;
    localparam int CAP_W  = 31;
    localparam int ADDR_W = 5;

    localparam int GRID_ROWS_DEF = 16;
    localparam int GRID_COLS_DEF = 16;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_GAIN_X    = 3'd0;
    localparam logic [2:0] REG_GAIN_Y    = 3'd1;
    localparam logic [2:0] REG_RATE      = 3'd2;
    localparam logic [2:0] REG_CAPACITY  = 3'd3;
    localparam logic [2:0] REG_SRC_EN    = 3'd4;
    localparam logic [2:0] REG_SRC_ROW   = 3'd5;
    localparam logic [2:0] REG_SRC_COL   = 3'd6;
    localparam logic [2:0] REG_SRC_VALUE = 3'd7;

    // Reset values of the registers
    localparam logic [GAIN_W-1:0] GAIN_X_RST    = 24'd1678;
    localparam logic [GAIN_W-1:0] GAIN_Y_RST    = 24'd1678;
    localparam logic [GAIN_W-1:0] RATE_RST      = 24'd838861;
    localparam logic [CAP_W-1:0]  CAPACITY_RST  = 31'd20132659;
    localparam logic              SRC_EN_RST    = 1'b1;
    localparam logic [ROW_W-1:0]  SRC_ROW_RST   = 10'd7;
    localparam logic [COL_W-1:0]  SRC_COL_RST   = 6'd7;
    localparam logic [DATA_W-1:0] SRC_VALUE_RST = 32'd33554432;

    // Coefficients handed to the arithmetic pipe
    typedef struct packed {
        logic [GAIN_W-1:0] gain_x;
        logic [GAIN_W-1:0] gain_y;
        logic [GAIN_W-1:0] rate;
        logic [CAP_W-1:0]  capacity;
    } t_coef;

    // Position tag that travels with each cell through the pipe
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             frame_end;
    } t_meta;

endpackage

@@ rtl/rds_cell.sv @@
// One word of the line-buffer shift chain.
module rds_cell (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [rds_pkg::DATA_W-1:0]  i_d,
    output logic [rds_pkg::DATA_W-1:0]  o_q
);

    logic [rds_pkg::DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

@@ rtl/rds_dp.sv @@
// Four-stage arithmetic pipe: differences, products, reaction, saturating sum.
module rds_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_push,
    input  logic signed [rds_pkg::DATA_W-1:0]  i_old,
    input  logic signed [rds_pkg::DATA_W-1:0]  i_left,
    input  logic signed [rds_pkg::DATA_W-1:0]  i_right,
    input  logic signed [rds_pkg::DATA_W-1:0]  i_up,
    input  logic signed [rds_pkg::DATA_W-1:0]  i_down,
    input  rds_pkg::t_meta                     i_meta,
    input  rds_pkg::t_coef                     i_coef,
    output logic                               o_valid,
    output logic [rds_pkg::DATA_W-1:0]         o_new_value,
    output rds_pkg::t_meta                     o_meta
);

    localparam logic signed [42:0] SAT_HI = 43'sd2147483647;
    localparam logic signed [42:0] SAT_LO = -43'sd2147483648;

    // stage A (comb, from the taps)
    logic signed [33:0] s_d2x;
    logic signed [33:0] s_d2y;
    logic signed [32:0] s_cd;
    logic               s_held;

    // stage 1
    logic               r1_v;
    logic signed [31:0] r1_old;
    logic signed [33:0] r1_d2x;
    logic signed [33:0] r1_d2y;
    logic signed [32:0] r1_cd;
    logic               r1_held;
    rds_pkg::t_meta     r1_meta;

    // stage 2
    logic signed [24:0] s_gx;
    logic signed [24:0] s_gy;
    logic signed [24:0] s_rate;
    logic signed [58:0] s_px_full;
    logic signed [58:0] s_py_full;
    logic signed [64:0] s_q_full;
    logic               r2_v;
    logic signed [31:0] r2_old;
    logic signed [34:0] r2_px;
    logic signed [34:0] r2_py;
    logic signed [40:0] r2_q;
    logic               r2_held;
    rds_pkg::t_meta     r2_meta;

    // stage 3
    logic signed [65:0] s_reac_full;
    logic               r3_v;
    logic signed [31:0] r3_old;
    logic signed [36:0] r3_sum;
    logic signed [41:0] r3_reac;
    logic               r3_held;
    rds_pkg::t_meta     r3_meta;

    // stage 4 / output
    logic signed [42:0] s_tot;
    logic [31:0]        s_res;
    logic               r_ov;
    logic [31:0]        r_out;
    rds_pkg::t_meta     r_out_meta;

    assign s_d2x  = 34'(i_left) + 34'(i_right) - (34'(i_old) <<< 1);
    assign s_d2y  = 34'(i_up) + 34'(i_down) - (34'(i_old) <<< 1);
    assign s_cd   = $signed({2'b00, i_coef.capacity}) - 33'(i_old);
    assign s_held = (33'(i_old) == $signed({2'b00, i_coef.capacity}));

    assign s_gx      = $signed({1'b0, i_coef.gain_x});
    assign s_gy      = $signed({1'b0, i_coef.gain_y});
    assign s_rate    = $signed({1'b0, i_coef.rate});
    assign s_px_full = s_gx * r1_d2x;
    assign s_py_full = s_gy * r1_d2y;
    assign s_q_full  = r1_old * r1_cd;

    assign s_reac_full = s_rate * r2_q;

    assign s_tot = 43'(r3_sum) + 43'(r3_reac);

    always_comb begin
        priority if (r3_held) begin
            s_res = r3_old;
        end else if (s_tot > SAT_HI) begin
            s_res = 32'h7FFF_FFFF;
        end else if (s_tot < SAT_LO) begin
            s_res = 32'h8000_0000;
        end else begin
            s_res = s_tot[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_push;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r_ov <= r3_v;
        end
    end

    // low bits dropped = floor toward minus infinity
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_old     <= i_old;
            r1_d2x     <= s_d2x;
            r1_d2y     <= s_d2y;
            r1_cd      <= s_cd;
            r1_held    <= s_held;
            r1_meta    <= i_meta;

            r2_old     <= r1_old;
            r2_px      <= s_px_full[58:24];
            r2_py      <= s_py_full[58:24];
            r2_q       <= s_q_full[64:24];
            r2_held    <= r1_held;
            r2_meta    <= r1_meta;

            r3_old     <= r2_old;
            r3_sum     <= 37'(r2_old) + 37'(r2_px) + 37'(r2_py);
            r3_reac    <= s_reac_full[65:24];
            r3_held    <= r2_held;
            r3_meta    <= r2_meta;

            r_out      <= s_res;
            r_out_meta <= r3_meta;
        end
    end

    assign o_valid     = r_ov;
    assign o_new_value = r_out;
    assign o_meta      = r_out_meta;

endmodule

@@ rtl/reaction_diffusion_stencil_step.sv @@
// Top level: config registers, raster counters, line-buffer chain and arithmetic pipe.
//
//  channel   direction  handshake               payload
//  -------   ---------  ---------------------   -----------------------------------------
//  input     in         i_valid / o_ready       i_cell_value
//  output    out        o_valid / i_ready       o_new_value, o_cell_row, o_cell_col,
//                                               o_frame_end
//  config    in         psel/penable/pready     paddr, pwrite, pwdata, prdata
//
// One input beat per cycle while the output is not stalled and no flush runs; each beat
// of rows 1 and up yields the cell one row above it through the four register stages of
// the arithmetic pipe. The last beat of a frame starts a flush of GRID_COLS beats that
// emits the final row; o_ready stays low during the flush.
// A stalled output beat freezes the whole pipe and the shift chain, and o_ready drops with it.
// Reset (synchronous, active low) clears counters, pipe valids and the config registers;
// the shift chain holds no reset and is never read before it is written.
module reaction_diffusion_stencil_step #(
    parameter int GRID_ROWS = rds_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = rds_pkg::GRID_COLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input cells
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rds_pkg::DATA_W-1:0]    i_cell_value,
    // results
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rds_pkg::DATA_W-1:0]    o_new_value,
    output logic [rds_pkg::ROW_W-1:0]     o_cell_row,
    output logic [rds_pkg::COL_W-1:0]     o_cell_col,
    output logic                          o_frame_end,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rds_pkg::ADDR_W-1:0]    paddr,
    input  logic [rds_pkg::DATA_W-1:0]    pwdata,
    output logic [rds_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam int RW    = rds_pkg::ROW_W;
    localparam int CW    = rds_pkg::COL_W;
    localparam int CHAIN = 2 * GRID_COLS;   // two rows of history
    localparam logic [RW-1:0] ROW_LAST = RW'(GRID_ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(GRID_COLS - 1);

    // ---------------- config registers ----------------
    logic [rds_pkg::GAIN_W-1:0] r_gain_x;
    logic [rds_pkg::GAIN_W-1:0] r_gain_y;
    logic [rds_pkg::GAIN_W-1:0] r_rate;
    logic [rds_pkg::CAP_W-1:0]  r_capacity;
    logic                       r_src_en;
    logic [RW-1:0]              r_src_row;
    logic [CW-1:0]              r_src_col;
    logic [rds_pkg::DATA_W-1:0] r_src_value;
    logic                       s_wr;
    logic [2:0]                 s_reg;

    assign pready = 1'b1;
    assign s_wr   = psel && penable && pwrite && pready;
    assign s_reg  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_x    <= rds_pkg::GAIN_X_RST;
            r_gain_y    <= rds_pkg::GAIN_Y_RST;
            r_rate      <= rds_pkg::RATE_RST;
            r_capacity  <= rds_pkg::CAPACITY_RST;
            r_src_en    <= rds_pkg::SRC_EN_RST;
            r_src_row   <= rds_pkg::SRC_ROW_RST;
            r_src_col   <= rds_pkg::SRC_COL_RST;
            r_src_value <= rds_pkg::SRC_VALUE_RST;
        end else if (s_wr) begin
            unique case (s_reg)
                rds_pkg::REG_GAIN_X:    r_gain_x    <= pwdata[23:0];
                rds_pkg::REG_GAIN_Y:    r_gain_y    <= pwdata[23:0];
                rds_pkg::REG_RATE:      r_rate      <= pwdata[23:0];
                rds_pkg::REG_CAPACITY:  r_capacity  <= pwdata[30:0];
                rds_pkg::REG_SRC_EN:    r_src_en    <= pwdata[0];
                rds_pkg::REG_SRC_ROW:   r_src_row   <= pwdata[RW-1:0];
                rds_pkg::REG_SRC_COL:   r_src_col   <= pwdata[CW-1:0];
                rds_pkg::REG_SRC_VALUE: r_src_value <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (s_reg)
            rds_pkg::REG_GAIN_X:    prdata = 32'(r_gain_x);
            rds_pkg::REG_GAIN_Y:    prdata = 32'(r_gain_y);
            rds_pkg::REG_RATE:      prdata = 32'(r_rate);
            rds_pkg::REG_CAPACITY:  prdata = 32'(r_capacity);
            rds_pkg::REG_SRC_EN:    prdata = 32'(r_src_en);
            rds_pkg::REG_SRC_ROW:   prdata = 32'(r_src_row);
            rds_pkg::REG_SRC_COL:   prdata = 32'(r_src_col);
            rds_pkg::REG_SRC_VALUE: prdata = r_src_value;
        endcase
    end

    // ---------------- raster control ----------------
    logic          r_flush;     // emitting the final row, no input taken
    logic          n_flush;
    logic [RW-1:0] r_row;
    logic [RW-1:0] n_row;
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic          s_en;        // pipe and chain may advance
    logic          s_accept;
    logic          s_flush_beat;
    logic          s_shift;
    logic          s_last;
    logic          s_push;
    logic          s_dp_valid;

    assign s_en         = !s_dp_valid || i_ready;
    assign o_ready      = s_en && !r_flush;
    assign s_accept     = i_valid && o_ready;
    assign s_flush_beat = s_en && r_flush;
    assign s_shift      = s_accept || s_flush_beat;
    assign s_last       = (r_row == ROW_LAST) && (r_col == COL_LAST);
    // row 0 only fills the buffer
    assign s_push       = s_flush_beat || (s_accept && (r_row != '0));

    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_flush = r_flush;
        priority if (s_accept) begin
            if (s_last) begin
                n_flush = 1'b1;
                n_col   = '0;
            end else if (r_col == COL_LAST) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end else if (s_flush_beat) begin
            if (r_col == COL_LAST) begin
                n_flush = 1'b0;
                n_row   = '0;
                n_col   = '0;
            end else begin
                n_col = r_col + 1'b1;
            end
        end else begin
            n_flush = r_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_flush <= 1'b0;
        end else begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_flush <= n_flush;
        end
    end

    // ---------------- line-buffer chain ----------------
    // tap k holds the word shifted in k+1 beats ago
    logic signed [31:0] s_in_val;
    logic        [31:0] s_shift_in;
    logic signed [31:0] s_tap [CHAIN];

    assign s_in_val = (r_src_en && (r_src_row == r_row) && (r_src_col == r_col))
                      ? $signed(r_src_value) : $signed(i_cell_value);
    // flush beats feed zeros; they are never read as data
    assign s_shift_in = r_flush ? '0 : s_in_val;

    for (genvar k = 0; k < CHAIN; k++) begin : g_chain
        if (k == 0) begin : g_head
            rds_cell u_cell (
                .i_clk (i_clk),
                .i_en  (s_shift),
                .i_d   (s_shift_in),
                .o_q   (s_tap[k])
            );
        end else begin : g_link
            rds_cell u_cell (
                .i_clk (i_clk),
                .i_en  (s_shift),
                .i_d   (s_tap[k-1]),
                .o_q   (s_tap[k])
            );
        end
    end

    // ---------------- stencil window ----------------
    // emitted cell sits one row above the current beat (or is the final row when flushing)
    logic signed [31:0] s_old;
    logic signed [31:0] s_left;
    logic signed [31:0] s_right;
    logic signed [31:0] s_up;
    logic signed [31:0] s_down;
    rds_pkg::t_meta     s_meta;
    rds_pkg::t_coef     s_coef;
    rds_pkg::t_meta     s_out_meta;

    always_comb begin
        s_meta.row       = r_flush ? r_row : (r_row - 1'b1);
        s_meta.col       = r_col;
        s_meta.frame_end = r_flush && (r_col == COL_LAST);
    end

    assign s_old   = s_tap[GRID_COLS-1];
    assign s_left  = (r_col == '0)        ? '0 : s_tap[GRID_COLS];
    assign s_right = (r_col == COL_LAST)  ? '0 : s_tap[GRID_COLS-2];
    assign s_up    = (s_meta.row == '0)   ? '0 : s_tap[CHAIN-1];
    assign s_down  = r_flush              ? '0 : s_in_val;

    assign s_coef.gain_x   = r_gain_x;
    assign s_coef.gain_y   = r_gain_y;
    assign s_coef.rate     = r_rate;
    assign s_coef.capacity = r_capacity;

    rds_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (s_en),
        .i_push      (s_push),
        .i_old       (s_old),
        .i_left      (s_left),
        .i_right     (s_right),
        .i_up        (s_up),
        .i_down      (s_down),
        .i_meta      (s_meta),
        .i_coef      (s_coef),
        .o_valid     (s_dp_valid),
        .o_new_value (o_new_value),
        .o_meta      (s_out_meta)
    );

    assign o_valid     = s_dp_valid;
    assign o_cell_row  = s_out_meta.row;
    assign o_cell_col  = s_out_meta.col;
    assign o_frame_end = s_out_meta.frame_end;

endmodule

@@ rtl/rds_chk.sv @@
// Port-level checker for the stencil step, bound to the top level.
module rds_chk #(
    parameter int GRID_ROWS = rds_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = rds_pkg::GRID_COLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_ready,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic [rds_pkg::DATA_W-1:0]    o_new_value,
    input  logic [rds_pkg::ROW_W-1:0]     o_cell_row,
    input  logic [rds_pkg::COL_W-1:0]     o_cell_col,
    input  logic                          o_frame_end
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_new_value) && $stable(o_cell_row)
            && $stable(o_cell_col) && $stable(o_frame_end))
        else $error("result beat changed while stalled");

    // a stalled output freezes the pipe, so no input is taken
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while output stalled");

    a_frame_end_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> (o_cell_row == GRID_ROWS - 1)
            && (o_cell_col == GRID_COLS - 1))
        else $error("frame end on wrong cell");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cell_row < GRID_ROWS) && (o_cell_col < GRID_COLS))
        else $error("result position outside grid");

endmodule

bind reaction_diffusion_stencil_step rds_chk #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
) u_rds_chk (.*);

@@ dv/rds_step_checker.sv @@
// Scoreboard for the stencil step: shadows the registers, predicts each result beat, compares.
module rds_step_checker
    import rds_pkg::*;
#(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cell_valid,
    input  logic              i_cell_ready,
    input  logic [DATA_W-1:0] i_cell_value,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [DATA_W-1:0] i_new_value,
    input  logic [ROW_W-1:0]  i_cell_row,
    input  logic [COL_W-1:0]  i_cell_col,
    input  logic              i_frame_end,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output int                o_fail_count,
    output int                o_backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              frame_end;
    } cell_result_t;

    localparam logic signed [95:0] SAT_HI = 96'sd2147483647;
    localparam logic signed [95:0] SAT_LO = -(96'sd2147483648);

    // register shadow
    logic [GAIN_W-1:0] gain_x_q, gain_y_q, rate_q;
    logic [CAP_W-1:0]  cap_q;
    logic              src_en_q;
    logic [ROW_W-1:0]  src_row_q;
    logic [COL_W-1:0]  src_col_q;
    logic [DATA_W-1:0] src_value_q;

    // three rolling rows, row r lives in slot r % 3
    logic signed [DATA_W-1:0] line_buf [3][GRID_COLS];
    int in_row, in_col;
    int fails;
    cell_result_t cells_due [$];

    // new value of cell (r,c) from the rows held now; all math in wide signed,
    // >>> 24 gives the floor the hardware truncation implies
    function automatic cell_result_t predict_cell(input int r, input int c);
        cell_result_t res;
        logic signed [95:0] mid, lf, rt, up, dn, cap, kx, ky, kr, sum;
        res.row       = ROW_W'(r);
        res.col       = COL_W'(c);
        res.frame_end = (r == GRID_ROWS - 1) && (c == GRID_COLS - 1);
        mid = line_buf[r % 3][c];
        lf  = '0;
        rt  = '0;
        up  = '0;
        dn  = '0;
        if (c > 0)             lf = line_buf[r % 3][c - 1];
        if (c + 1 < GRID_COLS) rt = line_buf[r % 3][c + 1];
        if (r > 0)             up = line_buf[(r + 2) % 3][c];
        if (r + 1 < GRID_ROWS) dn = line_buf[(r + 1) % 3][c];
        kx  = gain_x_q;
        ky  = gain_y_q;
        kr  = rate_q;
        cap = cap_q;
        if (mid == cap) begin
            // held cell
            res.value = mid[DATA_W-1:0];
        end else begin
            sum = mid
                + ((kx * (rt + lf - 2 * mid)) >>> 24)
                + ((ky * (up + dn - 2 * mid)) >>> 24)
                + ((kr * ((mid * (cap - mid)) >>> 24)) >>> 24);
            if (sum > SAT_HI)      res.value = 32'h7FFF_FFFF;
            else if (sum < SAT_LO) res.value = 32'h8000_0000;
            else                   res.value = sum[DATA_W-1:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        cell_result_t due;
        logic [DATA_W-1:0] v;
        if (!i_rst_n) begin
            gain_x_q    <= GAIN_X_RST;
            gain_y_q    <= GAIN_Y_RST;
            rate_q      <= RATE_RST;
            cap_q       <= CAPACITY_RST;
            src_en_q    <= SRC_EN_RST;
            src_row_q   <= SRC_ROW_RST;
            src_col_q   <= SRC_COL_RST;
            src_value_q <= SRC_VALUE_RST;
            in_row = 0;
            in_col = 0;
            fails  = 0;
            cells_due.delete();
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < GRID_COLS; j++)
                    line_buf[i][j] = '0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_GAIN_X:    gain_x_q    <= i_pwdata[GAIN_W-1:0];
                    REG_GAIN_Y:    gain_y_q    <= i_pwdata[GAIN_W-1:0];
                    REG_RATE:      rate_q      <= i_pwdata[GAIN_W-1:0];
                    REG_CAPACITY:  cap_q       <= i_pwdata[CAP_W-1:0];
                    REG_SRC_EN:    src_en_q    <= i_pwdata[0];
                    REG_SRC_ROW:   src_row_q   <= i_pwdata[ROW_W-1:0];
                    REG_SRC_COL:   src_col_q   <= i_pwdata[COL_W-1:0];
                    REG_SRC_VALUE: src_value_q <= i_pwdata;
                    default: ;
                endcase
            end

            if (i_res_valid && i_res_ready) begin
                if (cells_due.size() == 0) begin
                    $error("result beat row %0d col %0d with nothing expected",
                           i_cell_row, i_cell_col);
                    fails++;
                end else begin
                    due = cells_due.pop_front();
                    if (i_new_value !== due.value) begin
                        $error("new_value: expected %0d, got %0d",
                               $signed(due.value), $signed(i_new_value));
                        fails++;
                    end
                    if (i_cell_row !== due.row) begin
                        $error("cell_row: expected %0d, got %0d", due.row, i_cell_row);
                        fails++;
                    end
                    if (i_cell_col !== due.col) begin
                        $error("cell_col: expected %0d, got %0d", due.col, i_cell_col);
                        fails++;
                    end
                    if (i_frame_end !== due.frame_end) begin
                        $error("frame_end: expected %0b, got %0b", due.frame_end, i_frame_end);
                        fails++;
                    end
                end
            end

            if (i_cell_valid && i_cell_ready) begin
                v = i_cell_value;
                if (src_en_q && int'(src_row_q) == in_row && int'(src_col_q) == in_col)
                    v = src_value_q;
                line_buf[in_row % 3][in_col] = v;
                if (in_row >= 1)
                    cells_due.insert(cells_due.size(), predict_cell(in_row - 1, in_col));
                if (in_row == GRID_ROWS - 1 && in_col == GRID_COLS - 1)
                    for (int j = 0; j < GRID_COLS; j++)
                        cells_due.insert(cells_due.size(), predict_cell(in_row, j));
                in_col++;
                if (in_col >= GRID_COLS) begin
                    in_col = 0;
                    in_row = (in_row + 1 >= GRID_ROWS) ? 0 : in_row + 1;
                end
            end
        end
        o_fail_count <= fails;
        o_backlog    <= cells_due.size();
    end

endmodule

@@ dv/testbench.sv @@
// Testbench top: clock, reset, cell and register stimulus for the stencil step, and the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rds_pkg::*;

    localparam int ROWS   = GRID_ROWS_DEF;
    localparam int COLS   = GRID_COLS_DEF;
    localparam int N_REGS = 8;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [DATA_W-1:0] i_cell_value;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [DATA_W-1:0] o_new_value;
    logic [ROW_W-1:0]  o_cell_row;
    logic [COL_W-1:0]  o_cell_col;
    logic              o_frame_end;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int backlog;

    // calm = no idling on either side (one long stretch in the big phase)
    logic calm = 1'b0;

    // register words of the current setting, indexed by register code
    logic [DATA_W-1:0] reg_words [N_REGS];

    // Opening row and a half at reset settings: rails, held cells (== reset
    // capacity), sign flips next to each other so the row sums and the
    // reaction term saturate both ways. Row 0 beats give nothing back.
    localparam logic [DATA_W-1:0] CAP_RST_W = {1'b0, CAPACITY_RST};
    logic [DATA_W-1:0] opening_cells [24] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
        CAP_RST_W,     32'h0100_0000, 32'hFFFF_FFFF, 32'h0000_0001,
        CAP_RST_W,     CAP_RST_W,     32'h8000_0000, 32'h8000_0000,
        32'h00C0_0000, 32'hFF40_0000, 32'h7FFF_FFFF, 32'h0140_0000,
        32'h8000_0000, 32'h7FFF_FFFF, CAP_RST_W,     32'h0000_0000,
        32'h0200_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0001
    };

    reaction_diffusion_stencil_step #(
        .GRID_ROWS (ROWS),
        .GRID_COLS (COLS)
    ) uut (
        .i_clk, .i_rst_n,
        .i_valid, .o_ready, .i_cell_value,
        .o_valid, .i_ready, .o_new_value, .o_cell_row, .o_cell_col, .o_frame_end,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    rds_step_checker #(
        .GRID_ROWS (ROWS),
        .GRID_COLS (COLS)
    ) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cell_valid  (i_valid),
        .i_cell_ready  (o_ready),
        .i_cell_value  (i_cell_value),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_new_value   (o_new_value),
        .i_cell_row    (o_cell_row),
        .i_cell_col    (o_cell_col),
        .i_frame_end   (o_frame_end),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_backlog     (backlog)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

    // result side backpressure: ~25% stall, none while calm
    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(0, 99) >= 25);
    end

    function automatic void set_regs(
        input logic [DATA_W-1:0] gx, gy, rate, cap, en, row, col, val
    );
        reg_words[REG_GAIN_X]    = gx;
        reg_words[REG_GAIN_Y]    = gy;
        reg_words[REG_RATE]      = rate;
        reg_words[REG_CAPACITY]  = cap;
        reg_words[REG_SRC_EN]    = en;
        reg_words[REG_SRC_ROW]   = row;
        reg_words[REG_SRC_COL]   = col;
        reg_words[REG_SRC_VALUE] = val;
    endfunction

    // APB writes of every register, back to back; psel stays up across them
    // and only drops after the last access beat.
    task automatic load_regs();
        for (int k = 0; k < N_REGS; k++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_W'(4 * k);
            pwdata  <= reg_words[k];
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One input beat. Valid holds with the payload until o_ready is seen at
    // an edge; a gap only opens before the beat, never inside a handshake.
    task automatic push_cell(input logic [DATA_W-1:0] value, input logic quiet);
        while (!quiet && $urandom_range(0, 99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cell_value <= value;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Cell mix: plenty of held cells at the current capacity, rails for
    // saturation, small positive concentrations where the physics lives,
    // and raw 32-bit noise so every bit toggles.
    function automatic logic [DATA_W-1:0] pick_cell();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)      return reg_words[REG_CAPACITY];
        else if (sel < 25) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else if (sel < 60) return $urandom_range(0, 32'h03FF_FFFF);
        else               return $urandom();
    endfunction

    // n random beats; beats calm_lo .. calm_hi-1 run without idling anywhere
    task automatic run_cells(input int n, input int calm_lo, input int calm_hi);
        logic quiet;
        for (int k = 0; k < n; k++) begin
            quiet = (k >= calm_lo) && (k < calm_hi);
            calm <= quiet;
            push_cell(pick_cell(), quiet);
        end
    endtask

    // Drain: the edge after the last beat lets the scoreboard log it, then
    // wait out every expected result, then idle so that a row 0 beat
    // (which yields nothing) has left the pipe before the registers move.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        calm <= 1'b0;
        while (backlog != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin : stimulus
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_cell_value <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Opening beats at reset settings: row 0 and row 1 cols 0..7.
        foreach (opening_cells[k])
            push_cell(opening_cells[k], 1'b0);
        settle();

        // Rails: row gain and rate at max, column gain off, capacity at max
        // (so the +max rail is a held cell), source at (1,10) forcing -max.
        set_regs(32'hFF_FFFF, 32'h0, 32'hFF_FFFF, 32'h7FFF_FFFF,
                 32'd1, 32'd1, 32'd10, 32'h8000_0000);
        load_regs();
        run_cells(40, 0, 0);
        settle();

        // Other rail: only the column gain, zero capacity (zeros are held),
        // source enabled but parked outside the grid so it never fires.
        set_regs(32'h0, 32'hFF_FFFF, 32'h0, 32'h0,
                 32'd1, 32'd1023, 32'd62, 32'h7FFF_FFFF);
        load_regs();
        run_cells(30, 0, 0);
        settle();

        // Random gains, realistic capacity, source on the very last cell;
        // runs to the end of the frame so the flush row and frame_end show
        // up. Long calm stretch in the middle.
        set_regs($urandom_range(0, 32'hFF_FFFF), $urandom_range(0, 32'hFF_FFFF),
                 $urandom_range(0, 32'hFF_FFFF), $urandom_range(32'h0080_0000, 32'h0300_0000),
                 32'd1, 32'(ROWS - 1), 32'(COLS - 1), $urandom());
        load_regs();
        run_cells(ROWS * COLS - 94, 40, 110);
        settle();

        // Second frame after the wrap: source at the origin pinned to +max.
        set_regs($urandom_range(0, 32'hFF_FFFF), $urandom_range(0, 32'hFF_FFFF),
                 $urandom_range(0, 32'hFF_FFFF), $urandom_range(32'h0080_0000, 32'h0300_0000),
                 32'd1, 32'd0, 32'd0, 32'h7FFF_FFFF);
        load_regs();
        run_cells(COLS + 2, 0, 0);
        settle();

        // Source position inside this row but disabled: the raw beat goes in.
        set_regs($urandom_range(0, 32'hFF_FFFF), $urandom_range(0, 32'hFF_FFFF),
                 $urandom_range(0, 32'hFF_FFFF), $urandom_range(32'h0080_0000, 32'h0300_0000),
                 32'd0, 32'd1, 32'd6, $urandom());
        load_regs();
        run_cells(12, 0, 0);
        settle();

        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
